// ===== src/dq_pkg.sv =====
package dq_pkg;

    // Store geometry
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;

    // Stream payload widths (padded to whole bytes)
    localparam int IN_DATA_W  = ((VALUE_W + POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    typedef enum logic [KIND_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } dq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dq_stat_t;

endpackage

// ===== src/dq_ctrl.sv =====
module dq_ctrl
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dq_stat_t stat,
    output dq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance through capture, store access and result load
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready     = (state_reg == S_IDLE);
    assign cmd.load_in  = s_tvalid && (state_reg == S_IDLE);
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.load_out = (state_reg == S_DONE) && stat.out_free;

endmodule

// ===== src/dq_datapath.sv =====
module dq_datapath
    import dq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dq_cmd_t                cmd,
    output dq_stat_t               stat,
    input  logic [KIND_W-1:0]      in_kind,
    input  logic [VALUE_W-1:0]     in_value,
    input  logic [POS_W-1:0]       in_position,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STAT_W-1:0]      out_status,
    output logic [VALUE_W-1:0]     out_value,
    output logic [COUNT_W-1:0]     out_count
);

    // Captured transaction
    op_t                op_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   pos_reg;

    // Deque state
    logic [ADDR_W-1:0]  front_reg;
    logic [ADDR_W-1:0]  front_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // Store and its registered read
    logic [VALUE_W-1:0] store_mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    // Result held between access and output load
    status_t            res_status_reg;
    status_t            res_status_next;
    logic               res_take_reg;
    logic               res_take_next;

    // Output register
    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic [ADDR_W-1:0]  addr;
    logic               wr_en;
    logic               is_full;
    logic               is_empty;

    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= op_t'(in_kind);
            value_reg <= in_value;
            pos_reg   <= in_position;
        end
    end

    // Decode the operation into a ring address and the next pointer state
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        addr            = front_reg;
        wr_en           = 1'b0;
        res_status_next = ST_OK;
        res_take_next   = 1'b0;
        case (op_reg)
            OP_PUSH_FRONT:
            begin
                addr = front_reg - ADDR_W'(1);
                if (is_full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    front_next = addr;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                addr = front_reg + count_reg[ADDR_W-1:0];
                if (is_full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                addr = front_reg;
                if (is_empty)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    res_take_next = 1'b1;
                    front_next    = front_reg + ADDR_W'(1);
                    count_next    = count_reg - COUNT_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                addr = front_reg + count_reg[ADDR_W-1:0] - ADDR_W'(1);
                if (is_empty)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    res_take_next = 1'b1;
                    count_next    = count_reg - COUNT_W'(1);
                end
            end
            OP_READ:
            begin
                addr = front_reg + ADDR_W'(pos_reg);
                if (COUNT_W'(pos_reg) >= count_reg)
                begin
                    res_status_next = ST_RANGE;
                end
                else
                begin
                    res_take_next = 1'b1;
                end
            end
            default:
            begin
                res_status_next = ST_OK;
            end
        endcase
    end

    // Update pointers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Store access: write on push, registered read on every access
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (wr_en)
            begin
                store_mem[addr] <= value_reg;
            end
            rd_data_reg    <= store_mem[addr];
            res_status_reg <= res_status_next;
            res_take_reg   <= res_take_next;
        end
    end

    // Output register valid: set on load, drop on transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_take_reg ? rd_data_reg : '0;
            out_count_reg  <= count_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_value     = out_value_reg;
    assign out_count     = out_count_reg;

endmodule

// ===== src/double_ended_queue.sv =====
// Channel   Dir  tdata (low bit up)                  tuser       tlast
// s_*       in   push_value[31:0], position[37:32]   kind[2:0]   -
// m_*       out  out_value[31:0], entry_count[38:32] status[1:0] -
//
// Each transaction passes through three steps: capture, one store access, and
// the output load; the single-port store with its registered read sets this.
// A new transaction is taken while the previous result waits at the output.
// Reset clears the front pointer, the count, the controller state and the
// output valid flag; the store itself is not cleared. A stalled result keeps
// the next result in the load stage, and input is refused, until the output
// register frees up.
module double_ended_queue
    import dq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // push_value[31:0], position[37:32]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_value[31:0], entry_count[38:32]
    output logic [STAT_W-1:0]     m_tuser    // status[1:0]
);

    dq_cmd_t            cmd;
    dq_stat_t           stat;
    logic [VALUE_W-1:0] res_value;
    logic [COUNT_W-1:0] res_count;

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_tuser),
        .in_value    (s_tdata[VALUE_W-1:0]),
        .in_position (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_value   (res_value),
        .out_count   (res_count)
    );

    // Pack the result, zero fill to whole bytes
    assign m_tdata = OUT_DATA_W'({res_count, res_value});

endmodule

// ===== src/dq_checker.sv =====
module dq_checker
    import dq_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [KIND_W-1:0]     s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]     m_tuser
);

    logic [COUNT_W-1:0] count;
    logic [VALUE_W-1:0] value;

    assign count = m_tdata[VALUE_W+COUNT_W-1:VALUE_W];
    assign value = m_tdata[VALUE_W-1:0];

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> count <= FULL_COUNT)
        else $error("entry count beyond capacity");

    // Refused transactions return zero
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> value == '0)
        else $error("refused transaction returned a value");

    // Full refusal only at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> count == FULL_COUNT)
        else $error("full status with room left");

    // Empty refusal only when nothing is held
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_EMPTY) |-> count == '0)
        else $error("empty status with entries held");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
